/* rtl/core/wmmd_pkg.sv */
// shared types and constants for the waveform min/max decimator
// depends on nothing; imported by every module of the block
package wmmd_pkg;

  // sample format and level arithmetic
  localparam int SAMPLE_BITS = 16;
  localparam int LVL_FRAC    = SAMPLE_BITS + 8;    // unity product sits at 2^(LVL_FRAC-1)
  localparam int N_W         = LVL_FRAC + 1;       // offset product, 0 .. 2^LVL_FRAC
  localparam int PROD_W      = SAMPLE_BITS + 17;   // signed sample times unsigned gain
  localparam int LEVEL_W     = 32;
  localparam int WIDE_W      = N_W + LEVEL_W;      // offset product times full scale
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT    = 3'd0,
    REG_CHANNEL_SELECT   = 3'd1,
    REG_BUCKET_FRAMES    = 3'd2,
    REG_RUN_PIXELS       = 3'd3,
    REG_GAIN             = 3'd4,
    REG_OUTPUT_FORMAT    = 3'd5
  } cfg_reg_e;

  // output scale codes
  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_32 = 2'd2,
    FMT_32_ALT = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [2:0]  channel_select;
    logic [15:0] bucket_frames;
    logic [15:0] run_pixels;
    logic [15:0] gain;
    logic [1:0]  output_format;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_of_run;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] low_level;
    logic [31:0] high_level;
    logic [15:0] pixel_index;
    logic        last_pixel;
  } out_beat_t;

  // finished bucket handed from front to back
  typedef struct packed {
    logic signed [15:0] min_val;
    logic signed [15:0] max_val;
    logic [15:0]        pixel_index;
    logic               last_pixel;
  } bucket_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/waveform_minmax_decimator.sv */
// Min/max peak decimator for a waveform display. A sample beat is taken in
// every cycle while the two-entry bucket queue has room; the front end keeps
// the running extremes of the selected channel, comparing each of its beats
// with both. Each finished bucket goes through a scaling sequencer (gain
// multiply, clamp, scale, output register) that takes the next bucket only
// once the last pixel is taken, so short buckets or output back-pressure
// pace the input. Configuration is to be written through the plain write
// port only while the block is idle; the block itself does not enforce this.
module waveform_minmax_decimator import wmmd_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic       in_valid_i,
  input  in_beat_t   in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output out_beat_t  out_data_o,
  input  logic       out_ready_i
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  bucket_t q_push_data;
  bucket_t q_head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count    <= 4'd1;
      cfg_q.channel_select   <= 3'd0;
      cfg_q.bucket_frames    <= 16'd1;
      cfg_q.run_pixels       <= 16'd1;
      cfg_q.gain             <= 16'd256;
      cfg_q.output_format    <= FMT_8;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CHANNEL_COUNT:    cfg_q.channel_count    <= cfg_data_i[3:0];
        REG_CHANNEL_SELECT:   cfg_q.channel_select   <= cfg_data_i[2:0];
        REG_BUCKET_FRAMES:    cfg_q.bucket_frames    <= cfg_data_i;
        REG_RUN_PIXELS:       cfg_q.run_pixels       <= cfg_data_i;
        REG_GAIN:             cfg_q.gain             <= cfg_data_i;
        REG_OUTPUT_FORMAT:    cfg_q.output_format    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // sample front end
  wmmd_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // bucket queue
  wmmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  // scaling back end
  wmmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

  // queue never written when full nor read when empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("bucket pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("bucket popped from an empty queue");

  // a pixel leaving frees the sequencer for the next bucket
  a_out_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("pixel beat repeated after acceptance");

endmodule

/* rtl/core/wmmd_fifo.sv */
// short bucket queue between the front and the back
// depends on wmmd_pkg for the bucket type and depth
module wmmd_fifo import wmmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bucket_t push_data_i,
  input  logic    pop_i,
  output bucket_t head_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bucket_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/wmmd_front.sv */
// front end: takes sample beats, follows channel, frame and pixel position,
// keeps the bucket min/max and pushes finished buckets; depends on wmmd_pkg
module wmmd_front import wmmd_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_beat_t in_data_i,
  output logic     in_ready_o,
  input  q_stat_t  q_stat_i,
  output logic     q_push_o,
  output bucket_t  q_data_o
);

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);

  logic [CH_W-1:0]    pos_q, pos_d;
  logic [15:0]        fib_q, fib_d;
  logic [15:0]        pix_q, pix_d;
  logic signed [15:0] min_q, min_d;
  logic signed [15:0] max_q, max_d;
  logic               done_q, done_d;
  logic [CH_W-1:0]    chans;
  logic [16:0]        fpp_eff;
  logic [16:0]        pcnt_eff;
  logic               accept;

  // sanitised limits
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      chans = CH_W'(1);
    end else if (32'(cfg_i.channel_count) > MAX_CHANNELS) begin
      chans = CH_W'(MAX_CHANNELS);
    end else begin
      chans = CH_W'(cfg_i.channel_count);
    end
    fpp_eff  = (cfg_i.bucket_frames == '0) ? 17'd1 : {1'b0, cfg_i.bucket_frames};
    pcnt_eff = (cfg_i.run_pixels == '0) ? 17'd1 : {1'b0, cfg_i.run_pixels};
  end

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // per-beat position tracking and bucket close
  always_comb begin
    logic [CH_W:0] pos_inc;
    logic [16:0]   fib_inc;
    logic [16:0]   pix_inc;
    logic          last;
    pos_d  = pos_q;
    fib_d  = fib_q;
    pix_d  = pix_q;
    min_d  = min_q;
    max_d  = max_q;
    done_d = done_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    pos_inc  = '0;
    fib_inc  = '0;
    pix_inc  = '0;
    last     = 1'b0;
    if (accept) begin
      if (in_data_i.start_of_run) begin
        pos_d  = '0;
        fib_d  = '0;
        pix_d  = '0;
        min_d  = '0;
        max_d  = '0;
        done_d = 1'b0;
      end
      if (!done_d) begin
        if (32'(pos_d) == 32'(cfg_i.channel_select)) begin
          if (in_data_i.sample > max_d) max_d = in_data_i.sample;
          if (in_data_i.sample < min_d) min_d = in_data_i.sample;
        end
        pos_inc = {1'b0, pos_d} + 1'b1;
        if (pos_inc < {1'b0, chans}) begin
          pos_d = pos_inc[CH_W-1:0];
        end else begin
          pos_d   = '0;
          fib_inc = {1'b0, fib_d} + 17'd1;
          if (fib_inc < fpp_eff) begin
            fib_d = fib_inc[15:0];
          end else begin
            pix_inc  = {1'b0, pix_d} + 17'd1;
            last     = (pix_inc >= pcnt_eff);
            q_push_o = 1'b1;
            q_data_o.min_val     = min_d;
            q_data_o.max_val     = max_d;
            q_data_o.pixel_index = pix_d;
            q_data_o.last_pixel  = last;
            fib_d  = '0;
            min_d  = '0;
            max_d  = '0;
            pix_d  = pix_inc[15:0];
            done_d = last;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fib_q  <= '0;
      pix_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      done_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      fib_q  <= fib_d;
      pix_q  <= pix_d;
      min_q  <= min_d;
      max_q  <= max_d;
      done_q <= done_d;
    end
  end

endmodule

/* rtl/core/wmmd_back.sv */
// back end: pops buckets, applies gain, clamps and scales both extremes,
// and holds the pixel beat in an output register; depends on wmmd_pkg
module wmmd_back import wmmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_stat_t   q_stat_i,
  input  bucket_t   q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_beat_t out_data_o,
  input  logic      out_ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SCALE,
    ST_OUT
  } state_e;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (LVL_FRAC - 1);

  state_e                    state_q;
  logic signed [PROD_W-1:0]  prod_lo_q, prod_hi_q;
  logic [N_W-1:0]            n_lo_q, n_hi_q;
  logic [15:0]               pix_q;
  logic                      last_q;
  out_beat_t                 out_q;
  logic signed [PROD_W-1:0]  prod_lo, prod_hi;
  logic [N_W-1:0]            n_lo, n_hi;
  logic [LEVEL_W-1:0]        lvl_lo, lvl_hi;

  // sample times unsigned q8.8 gain
  function automatic logic signed [PROD_W-1:0] apply_gain(logic signed [15:0] v,
                                                          logic [15:0] g);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
    a = PROD_W'(v);
    b = $signed({{(PROD_W-16){1'b0}}, g});
    return a * b;
  endfunction

  // clamp to +-unity and offset to the unsigned range
  function automatic logic [N_W-1:0] clamp_offset(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] c;
    c = p;
    if (c > HALF) c = HALF;
    if (c < -HALF) c = -HALF;
    return N_W'(c + HALF);
  endfunction

  // floor of full scale times n over 2^LVL_FRAC; full scale is 2^k-1
  function automatic logic [LEVEL_W-1:0] scale_level(logic [N_W-1:0] n, logic [1:0] fmt);
    logic [WIDE_W-1:0]  ext;
    logic [WIDE_W-1:0]  wide;
    logic [LEVEL_W-1:0] fs;
    ext = WIDE_W'(n);
    case (fmt_e'(fmt))
      FMT_8: begin
        fs   = LEVEL_W'(8'hFF);
        wide = (ext << 8) - ext;
      end
      FMT_16: begin
        fs   = LEVEL_W'(16'hFFFF);
        wide = (ext << 16) - ext;
      end
      default: begin
        fs   = '1;
        wide = (ext << LEVEL_W) - ext;
      end
    endcase
    if (n[N_W-1]) return fs;
    return wide[LVL_FRAC +: LEVEL_W];
  endfunction

  assign prod_lo = apply_gain(q_head_i.min_val, cfg_i.gain);
  assign prod_hi = apply_gain(q_head_i.max_val, cfg_i.gain);
  assign n_lo    = clamp_offset(prod_lo_q);
  assign n_hi    = clamp_offset(prod_hi_q);
  assign lvl_lo  = scale_level(n_lo_q, cfg_i.output_format);
  assign lvl_hi  = scale_level(n_hi_q, cfg_i.output_format);

  assign q_pop_o     = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

  // scaling sequencer: multiply, clamp, scale, hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prod_lo_q <= '0;
      prod_hi_q <= '0;
      n_lo_q    <= '0;
      n_hi_q    <= '0;
      pix_q     <= '0;
      last_q    <= 1'b0;
      out_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            prod_lo_q <= prod_lo;
            prod_hi_q <= prod_hi;
            pix_q     <= q_head_i.pixel_index;
            last_q    <= q_head_i.last_pixel;
            state_q   <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          n_lo_q  <= n_lo;
          n_hi_q  <= n_hi;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          out_q.low_level   <= lvl_lo;
          out_q.high_level  <= lvl_hi;
          out_q.pixel_index <= pix_q;
          out_q.last_pixel  <= last_q;
          state_q           <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb_waveform_minmax_decimator.sv */
// self-checking testbench for the waveform min/max decimator
// depends on wmmd_pkg and waveform_minmax_decimator; stimulus is a directed
// table followed by random runs, each pixel checked against the table or an in-bench predictor
`timescale 1ns / 100ps

module tb_waveform_minmax_decimator;
  import wmmd_pkg::*;

  localparam int          MAX_CH       = 8;
  localparam int unsigned ITEMS        = 1700;
  localparam int unsigned SETTLE       = 16;     // queue plus scaling sequencer, with margin
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam longint      HALF         = longint'(1) << (LVL_FRAC - 1);
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  // one row of the directed table
  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_idx;
    logic [15:0] value;
    in_beat_t    beat;
    bit          typed;
    out_beat_t   px;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic       in_valid_i;
  in_beat_t   in_data_i;
  logic       in_ready_o;
  logic       out_valid_o;
  out_beat_t  out_data_o;
  logic       out_ready_i;

  // predictor copy of the registers and the bucket state
  cfg_t shadow_cfg = '{channel_count: 4'd1, channel_select: 3'd0, bucket_frames: 16'd1,
                       run_pixels: 16'd1, gain: 16'd256, output_format: FMT_8};
  int unsigned        chan_pos = 0;
  int unsigned        frame_cnt = 0;
  logic [15:0]        pix_cnt = '0;
  logic signed [15:0] run_lo = '0;
  logic signed [15:0] run_hi = '0;
  bit                 idle = 1'b1;

  out_beat_t   pixel_q[$];
  stim_row_t   plan[$];
  int unsigned live_items = 0;
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;
  bit          hold_out = 1'b0;

  waveform_minmax_decimator #(.MAX_CHANNELS(MAX_CH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // gain, clamp to full scale, offset to unsigned and scale to the output width
  function automatic logic [31:0] to_level(input logic signed [15:0] v);
    longint          p;
    longint unsigned n;
    longint unsigned fs;
    longint unsigned w;
    p = longint'(v) * longint'(shadow_cfg.gain);
    if (p > HALF) p = HALF;
    else if (p < -HALF) p = -HALF;
    n = p + HALF;
    case (fmt_e'(shadow_cfg.output_format))
      FMT_8:   fs = 64'd255;
      FMT_16:  fs = 64'd65535;
      default: fs = 64'hFFFF_FFFF;
    endcase
    w = (fs * n) >> LVL_FRAC;
    return w[31:0];
  endfunction

  // fold one sample into the bucket; returns 1 when a pixel comes out
  function automatic bit fold_sample(input in_beat_t b, output out_beat_t px,
                                     output bit ignored);
    int unsigned chans;
    int unsigned fpp;
    int unsigned pcnt;
    bit          last;
    px = '0;
    ignored = 1'b0;
    chans = shadow_cfg.channel_count;
    if (chans == 0) chans = 1;
    if (chans > MAX_CH) chans = MAX_CH;
    fpp = (shadow_cfg.bucket_frames == 0) ? 1 : shadow_cfg.bucket_frames;
    pcnt = (shadow_cfg.run_pixels == 0) ? 1 : shadow_cfg.run_pixels;
    if (b.start_of_run) begin
      chan_pos = 0;
      frame_cnt = 0;
      pix_cnt = '0;
      run_lo = '0;
      run_hi = '0;
      idle = 1'b0;
    end
    if (idle) begin
      ignored = 1'b1;
      return 1'b0;
    end
    if (chan_pos == shadow_cfg.channel_select) begin
      if (b.sample > run_hi) run_hi = b.sample;
      if (b.sample < run_lo) run_lo = b.sample;
    end
    chan_pos++;
    if (chan_pos < chans) return 1'b0;
    chan_pos = 0;
    frame_cnt++;
    if (frame_cnt < fpp) return 1'b0;
    last = (32'(pix_cnt) + 1) >= pcnt;
    px.low_level = to_level(run_lo);
    px.high_level = to_level(run_hi);
    px.pixel_index = pix_cnt;
    px.last_pixel = last;
    frame_cnt = 0;
    run_lo = '0;
    run_hi = '0;
    pix_cnt = pix_cnt + 16'd1;
    if (last) idle = 1'b1;
    return 1'b1;
  endfunction

  // idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void plan_cfg(input cfg_reg_e r, input logic [15:0] v);
    stim_row_t row;
    row = '{reg_idx: REG_CHANNEL_COUNT, default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = r;
    row.value = v;
    plan.push_back(row);
  endfunction

  // known pixels in the table are always the single pixel of a one-pixel run
  function automatic void plan_beat(input logic [15:0] s, input bit sor, input bit typed = 0,
                                    input logic [31:0] lo = '0, input logic [31:0] hi = '0);
    stim_row_t row;
    row = '{reg_idx: REG_CHANNEL_COUNT, default: '0};
    row.reg_idx = REG_CHANNEL_COUNT;
    row.beat.sample = s;
    row.beat.start_of_run = sor;
    row.typed = typed;
    row.px.low_level = lo;
    row.px.high_level = hi;
    row.px.pixel_index = '0;
    row.px.last_pixel = 1'b1;
    plan.push_back(row);
  endfunction

  task automatic cfg_write(input cfg_reg_e r, input logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (r)
      REG_CHANNEL_COUNT:    shadow_cfg.channel_count = v[3:0];
      REG_CHANNEL_SELECT:   shadow_cfg.channel_select = v[2:0];
      REG_BUCKET_FRAMES:    shadow_cfg.bucket_frames = v;
      REG_RUN_PIXELS:       shadow_cfg.run_pixels = v;
      REG_GAIN:             shadow_cfg.gain = v;
      REG_OUTPUT_FORMAT:    shadow_cfg.output_format = v[1:0];
      default: ;
    endcase
  endtask

  // offer one sample beat after a random gap and predict its pixel on acceptance
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t known);
    int unsigned gap;
    out_beat_t   px;
    bit          ignored;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (fold_sample(b, px, ignored)) pixel_q.push_back(typed ? known : px);
    if (!ignored) live_items++;
  endtask

  // stop sending and wait for every pending pixel, then let the pipeline settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // pixel checker
  always @(posedge clk_i) begin : pixel_check
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $error("pixel_index: no pixel expected, got %0d", out_data_o.pixel_index);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data_o.low_level !== want.low_level) begin
          $error("low_level: expected %0h, got %0h", want.low_level, out_data_o.low_level);
          mismatches++;
        end
        if (out_data_o.high_level !== want.high_level) begin
          $error("high_level: expected %0h, got %0h", want.high_level, out_data_o.high_level);
          mismatches++;
        end
        if (out_data_o.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index,
                 out_data_o.pixel_index);
          mismatches++;
        end
        if (out_data_o.last_pixel !== want.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want.last_pixel, out_data_o.last_pixel);
          mismatches++;
        end
      end
    end
  end

  // receiver: random back-pressure, one long hold on request
  initial begin : receiver
    int unsigned dur;
    bit          rdy;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        rdy = 1'b0;
        dur = HOLD_CYCLES;
        hold_out = 1'b0;
      end else if (no_idle) begin
        rdy = 1'b1;
        dur = 1;
      end else begin
        rdy = ($urandom_range(0, 2) != 0);
        dur = rdy ? $urandom_range(1, 10) : pick_gap() + 1;
      end
      out_ready_i <= rdy;
      repeat (dur) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // main stimulus
  initial begin : driver
    stim_row_t   row;
    in_beat_t    b;
    bit          quiet;
    int unsigned phase;
    int unsigned eff;
    int unsigned fpp_e;
    int unsigned pc_e;
    int unsigned cap;
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    logic [3:0]  chans_w;
    logic [2:0]  sel_w;
    logic [15:0] fpp_w;
    logic [15:0] pc_w;
    logic [15:0] gain_w;
    logic [1:0]  fmt_w;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_CHANNEL_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;

    // directed table: reset settings first, then extremes and corner settings
    plan_beat(16'h7FFF, 1, 1, 32'd127, 32'd254);
    plan_beat(16'h8000, 1, 1, 32'd0, 32'd127);
    plan_beat(16'h1234, 0);                        // idle, ignored
    plan_beat(16'h0000, 1, 1, 32'd127, 32'd127);
    plan_cfg(REG_GAIN, 16'hFFFF);
    plan_cfg(REG_OUTPUT_FORMAT, 16'(FMT_32));
    plan_beat(16'h0001, 1);
    plan_beat(16'h8000, 1, 1, 32'h0, 32'h7FFF_FFFF);
    plan_beat(16'h7FFF, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    plan_cfg(REG_OUTPUT_FORMAT, 16'(FMT_32_ALT));
    plan_cfg(REG_GAIN, 16'h0000);
    plan_beat(16'h7FFF, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // two channels, second measured, two frames per pixel, three pixels
    plan_cfg(REG_OUTPUT_FORMAT, 16'(FMT_16));
    plan_cfg(REG_GAIN, 16'd256);
    plan_cfg(REG_CHANNEL_COUNT, 16'd2);
    plan_cfg(REG_CHANNEL_SELECT, 16'd1);
    plan_cfg(REG_BUCKET_FRAMES, 16'd2);
    plan_cfg(REG_RUN_PIXELS, 16'd3);
    plan_beat(16'h4000, 1);
    plan_beat(16'h8000, 0);
    plan_beat(16'h7FFF, 0);
    plan_beat(16'h2000, 0);
    plan_beat(16'h1111, 0);
    plan_beat(16'h7FFF, 0);
    // restart while running
    plan_beat(16'h0100, 1);
    plan_beat(16'hF000, 0);
    plan_beat(16'h0000, 0);
    plan_beat(16'h0FFF, 0);
    // zero counts behave as one
    plan_cfg(REG_CHANNEL_COUNT, 16'd0);
    plan_cfg(REG_CHANNEL_SELECT, 16'd0);
    plan_cfg(REG_BUCKET_FRAMES, 16'd0);
    plan_cfg(REG_RUN_PIXELS, 16'd0);
    plan_beat(16'h5555, 1);
    plan_beat(16'hAAAA, 1);
    // selected channel missing: mid level
    plan_cfg(REG_CHANNEL_COUNT, 16'd3);
    plan_cfg(REG_CHANNEL_SELECT, 16'd5);
    plan_cfg(REG_BUCKET_FRAMES, 16'd1);
    plan_cfg(REG_RUN_PIXELS, 16'd1);
    plan_cfg(REG_OUTPUT_FORMAT, 16'(FMT_8));
    plan_beat(16'h7FFF, 1);
    plan_beat(16'h8000, 0);
    plan_beat(16'h7FFF, 0, 1, 32'd127, 32'd127);
    plan_beat(16'h1234, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (!quiet) begin
          quiesce();
          quiet = 1'b1;
        end
        cfg_write(row.reg_idx, row.value);
      end else begin
        if (quiet) cfg_we_i <= 1'b0;
        quiet = 1'b0;
        send_beat(row.beat, 1'b0 | row.typed, row.px);
      end
    end

    // random phases of well-formed runs with noise
    for (phase = 0; live_items < ITEMS; phase++) begin
      quiesce();
      case ($urandom_range(0, 9))
        0:       chans_w = 4'd0;
        1:       chans_w = 4'($urandom_range(9, 15));
        2:       chans_w = 4'd8;
        default: chans_w = 4'($urandom_range(1, 3));
      endcase
      eff = (chans_w == 0) ? 1 : ((chans_w > MAX_CH) ? MAX_CH : chans_w);
      sel_w = ($urandom_range(0, 6) != 0) ? 3'($urandom_range(0, eff - 1))
                                          : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0:       fpp_w = 16'd0;
        1:       fpp_w = 16'd1;
        default: fpp_w = 16'($urandom_range(1, 6));
      endcase
      pc_w = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
      case ($urandom_range(0, 7))
        0:       gain_w = 16'd0;
        1:       gain_w = 16'hFFFF;
        2:       gain_w = 16'd256;
        3, 4:    gain_w = 16'($urandom_range(64, 1024));
        default: gain_w = 16'($urandom());
      endcase
      fmt_w = 2'($urandom_range(0, 3));
      cap = $urandom_range(40, 150);
      no_idle = ($urandom_range(0, 4) == 0);

      // first phases: input stall under a long receiver hold, then the largest sizes
      if (phase == 0) begin
        chans_w = 4'd1;
        sel_w = 3'd0;
        fpp_w = 16'd1;
        pc_w = 16'd40;
        cap = 80;
        no_idle = 1'b1;
        hold_out = 1'b1;
      end else if (phase == 1) begin
        fpp_w = 16'hFFFF;
        cap = 40;
      end else if (phase == 2) begin
        chans_w = 4'd1;
        sel_w = 3'd0;
        fpp_w = 16'd1;
        pc_w = 16'hFFFF;
        cap = 150;
      end
      eff = (chans_w == 0) ? 1 : ((chans_w > MAX_CH) ? MAX_CH : chans_w);

      cfg_write(REG_CHANNEL_COUNT, 16'(chans_w));
      cfg_write(REG_CHANNEL_SELECT, 16'(sel_w));
      cfg_write(REG_BUCKET_FRAMES, fpp_w);
      cfg_write(REG_RUN_PIXELS, pc_w);
      cfg_write(REG_GAIN, gain_w);
      cfg_write(REG_OUTPUT_FORMAT, 16'(fmt_w));
      cfg_we_i <= 1'b0;

      fpp_e = (fpp_w == 0) ? 1 : fpp_w;
      pc_e = (pc_w == 0) ? 1 : pc_w;
      sent = 0;
      while (sent < cap && live_items < ITEMS) begin
        // one run, sometimes cut short, with the odd restart inside
        run_len = eff * fpp_e * pc_e;
        if ($urandom_range(0, 9) == 0) run_len = $urandom_range(1, run_len);
        for (k = 0; k < run_len && sent < cap; k++) begin
          b.sample = rand_sample();
          b.start_of_run = (k == 0) || ($urandom_range(0, 99) < 2);
          send_beat(b, 1'b0, '0);
          sent++;
        end
        // stray beats while the block waits for a start
        repeat ($urandom_range(0, 3)) begin
          b.sample = rand_sample();
          b.start_of_run = 1'b0;
          send_beat(b, 1'b0, '0);
          sent++;
        end
      end
    end

    no_idle = 1'b0;
    quiesce();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
